// ===== rtl/coap_pkg.sv =====
package coap_pkg;

  localparam int unsigned PosW = 11;
  localparam logic [PosW-1:0] MaxMessageBytes = 11'd1024;
  localparam logic [PosW-1:0] PosSat = 11'd2047;
  localparam logic [8:0] ExtLenBase = 9'd15;
  localparam logic [3:0] ExtNibble = 4'hF;

  typedef enum logic [2:0] {
    PH_H0  = 3'd0,
    PH_H1  = 3'd1,
    PH_H2  = 3'd2,
    PH_H3  = 3'd3,
    PH_OPT = 3'd4,
    PH_EXT = 3'd5,
    PH_VAL = 3'd6,
    PH_PAY = 3'd7
  } phase_e;

  typedef enum logic [2:0] {
    KIND_HEADER  = 3'd0,
    KIND_OPT_HDR = 3'd1,
    KIND_EXT_LEN = 3'd2,
    KIND_OPT_VAL = 3'd3,
    KIND_PAYLOAD = 3'd4,
    KIND_DISCARD = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_SHORT = 2'd1,
    ERR_TRUNC = 2'd2,
    ERR_LONG  = 2'd3
  } err_e;

  typedef struct packed {
    phase_e          phase;
    logic [PosW-1:0] byte_pos;
    logic [3:0]      opts_left;
    logic [7:0]      cur_opt;
    logic [8:0]      val_rem;
    logic [8:0]      cur_len;
    logic [1:0]      version;
    logic [1:0]      msg_type;
    logic [7:0]      code;
    logic [15:0]     msg_id;
    err_e            err_latch;
    logic            seen_opt;
    logic            cur_rep;
  } state_t;

  localparam state_t StateReset = '{
    phase:     PH_H0,
    byte_pos:  '0,
    opts_left: '0,
    cur_opt:   '0,
    val_rem:   '0,
    cur_len:   '0,
    version:   '0,
    msg_type:  '0,
    code:      '0,
    msg_id:    '0,
    err_latch: ERR_NONE,
    seen_opt:  1'b0,
    cur_rep:   1'b0
  };

  typedef struct packed {
    kind_e       kind;
    logic [1:0]  version;
    logic [1:0]  msg_type;
    logic [7:0]  code;
    logic [15:0] msg_id;
    logic [7:0]  option_number;
    logic [8:0]  option_length;
    logic [7:0]  value_byte;
    logic        repeated;
    logic        last;
    err_e        error;
  } result_t;

endpackage

// ===== rtl/coap_decode.sv =====
module coap_decode import coap_pkg::*; (
  input  state_t     st_i,
  input  logic [7:0] data_i,
  input  logic       eop_i,
  output state_t     st_o,
  output result_t    res_o
);

  state_t     st_upd;
  kind_e      kind;
  err_e       err;
  logic       opt_kind;
  logic [7:0] vb;
  logic       active;
  logic [3:0] opts_next;
  logic [8:0] rem_next;

  // a byte is parsed only while no error is held and the size limit is not hit
  assign active    = (st_i.err_latch == ERR_NONE) && (st_i.byte_pos < MaxMessageBytes);
  assign opts_next = (st_i.opts_left != '0) ? st_i.opts_left - 4'd1 : st_i.opts_left;
  assign rem_next  = (st_i.val_rem != '0) ? st_i.val_rem - 9'd1 : st_i.val_rem;

  // next state
  always_comb begin
    logic [3:0] delta;
    logic [3:0] nib;

    delta  = data_i[7:4];
    nib    = data_i[3:0];
    st_upd = st_i;

    if (active) begin
      unique case (st_i.phase)
        PH_H0: begin
          st_upd.version   = data_i[7:6];
          st_upd.msg_type  = data_i[5:4];
          st_upd.code      = '0;
          st_upd.msg_id    = '0;
          st_upd.opts_left = data_i[3:0];
          st_upd.phase     = PH_H1;
        end
        PH_H1: begin
          st_upd.code  = data_i;
          st_upd.phase = PH_H2;
        end
        PH_H2: begin
          st_upd.msg_id[15:8] = data_i;
          st_upd.phase        = PH_H3;
        end
        PH_H3: begin
          st_upd.msg_id[7:0] = data_i;
          st_upd.phase       = (st_i.opts_left != '0) ? PH_OPT : PH_PAY;
        end
        PH_OPT: begin
          st_upd.cur_opt   = st_i.cur_opt + {4'b0, delta};
          st_upd.cur_rep   = st_i.seen_opt && (delta == '0);
          st_upd.seen_opt  = 1'b1;
          st_upd.opts_left = opts_next;
          if (nib == ExtNibble) begin
            // length continues in the next byte
            st_upd.cur_len = ExtLenBase;
            st_upd.phase   = PH_EXT;
          end else begin
            st_upd.cur_len = {5'b0, nib};
            st_upd.val_rem = {5'b0, nib};
            if (nib != '0) st_upd.phase = PH_VAL;
            else st_upd.phase = (opts_next != '0) ? PH_OPT : PH_PAY;
          end
        end
        PH_EXT: begin
          st_upd.cur_len = ExtLenBase + {1'b0, data_i};
          st_upd.val_rem = ExtLenBase + {1'b0, data_i};
          st_upd.phase   = PH_VAL;
        end
        PH_VAL: begin
          st_upd.val_rem = rem_next;
          if (rem_next == '0) st_upd.phase = (st_i.opts_left != '0) ? PH_OPT : PH_PAY;
        end
        default: begin
          // payload leaves the state alone
        end
      endcase
    end

    if (err != ERR_NONE) st_upd.err_latch = err;
    if (st_i.byte_pos != PosSat) st_upd.byte_pos = st_i.byte_pos + 11'd1;
  end

  // outputs
  always_comb begin
    kind     = KIND_DISCARD;
    err      = ERR_NONE;
    opt_kind = 1'b0;
    vb       = '0;

    if (st_i.err_latch != ERR_NONE) begin
      err = st_i.err_latch;
    end else if (!active) begin
      err = ERR_LONG;
    end else begin
      unique case (st_i.phase)
        PH_H0, PH_H1, PH_H2: begin
          kind = KIND_HEADER;
          if (eop_i) err = ERR_SHORT;
        end
        PH_H3: begin
          kind = KIND_HEADER;
          if (eop_i && st_i.opts_left != '0) err = ERR_TRUNC;
        end
        PH_OPT: begin
          kind     = KIND_OPT_HDR;
          opt_kind = 1'b1;
          // an extended nibble always owes more bytes
          if (eop_i && (data_i[3:0] != '0 || opts_next != '0)) err = ERR_TRUNC;
        end
        PH_EXT: begin
          kind     = KIND_EXT_LEN;
          opt_kind = 1'b1;
          if (eop_i) err = ERR_TRUNC;
        end
        PH_VAL: begin
          kind     = KIND_OPT_VAL;
          opt_kind = 1'b1;
          vb       = data_i;
          if (eop_i && (rem_next != '0 || st_i.opts_left != '0)) err = ERR_TRUNC;
        end
        default: begin
          kind = KIND_PAYLOAD;
          vb   = data_i;
        end
      endcase
    end
  end

  always_comb begin
    res_o.kind          = kind;
    res_o.version       = st_upd.version;
    res_o.msg_type      = st_upd.msg_type;
    res_o.code          = st_upd.code;
    res_o.msg_id        = st_upd.msg_id;
    res_o.option_number = opt_kind ? st_upd.cur_opt : '0;
    res_o.option_length = opt_kind ? st_upd.cur_len : '0;
    res_o.value_byte    = vb;
    res_o.repeated      = opt_kind & st_upd.cur_rep;
    res_o.last          = eop_i;
    res_o.error         = err;
  end

  // message done: back to the start of the next one
  assign st_o = eop_i ? StateReset : st_upd;

endmodule

// ===== rtl/coap_message_parser_top.sv =====
// channel   direction  handshake                 payload
// request   in         in_valid_i / in_stall_o   data_byte_i, end_of_packet_i
// result    out        out_valid_o / out_stall_i kind_o .. error_o (11 fields)
//
// one byte per cycle while the result channel is not stalled: each request is decoded
// combinationally and lands in the result register, so a result appears in the cycle after its request is taken.
// in_stall_o is high only while a held result is stalled; a request is taken
// in the same cycle that the held result leaves.
// reset clears the parser state and empties the result register.
module coap_message_parser_top import coap_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_packet_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  kind_o,
  output logic [1:0]  version_o,
  output logic [1:0]  msg_type_o,
  output logic [7:0]  code_o,
  output logic [15:0] msg_id_o,
  output logic [7:0]  option_number_o,
  output logic [8:0]  option_length_o,
  output logic [7:0]  value_byte_o,
  output logic        repeated_o,
  output logic        last_o,
  output logic [1:0]  error_o
);

  state_t  st_q, st_d;
  result_t res_q, res_d;
  logic    out_valid_q;
  logic    in_acc;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_acc     = in_valid_i & ~in_stall_o;

  coap_decode u_decode (
    .st_i   (st_q),
    .data_i (data_byte_i),
    .eop_i  (end_of_packet_i),
    .st_o   (st_d),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= StateReset;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        st_q <= st_d;
      end
      if (in_acc) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = res_q.kind;
  assign version_o       = res_q.version;
  assign msg_type_o      = res_q.msg_type;
  assign code_o          = res_q.code;
  assign msg_id_o        = res_q.msg_id;
  assign option_number_o = res_q.option_number;
  assign option_length_o = res_q.option_length;
  assign value_byte_o    = res_q.value_byte;
  assign repeated_o      = res_q.repeated;
  assign last_o          = res_q.last;
  assign error_o         = res_q.error;

  a_err_discard: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && st_q.err_latch != ERR_NONE |=>
      res_q.kind == KIND_DISCARD && res_q.error == $past(st_q.err_latch))
    else $error("latched error did not force discard");

  a_eop_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && end_of_packet_i |=>
      st_q.phase == PH_H0 && st_q.byte_pos == '0 && st_q.err_latch == ERR_NONE)
    else $error("message state not cleared after last byte");

  a_val_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.phase == PH_VAL |-> st_q.val_rem != '0)
    else $error("value phase with nothing left to read");

  a_opt_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.kind != KIND_OPT_HDR && res_q.kind != KIND_EXT_LEN &&
      res_q.kind != KIND_OPT_VAL |->
      res_q.option_number == '0 && res_q.option_length == '0 && !res_q.repeated)
    else $error("option fields set outside an option");

endmodule
